// ===== hw/rtl/sle_pkg.sv =====
// sle_pkg: shared types, constants and helper functions for the string literal escaper.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int MaxSequence = 6;
  localparam int HeldCntW    = $clog2(MaxSequence + 1);
  localparam int QueueDepth  = 2;
  localparam int QPtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW       = $clog2(QueueDepth + 1);

  // locale register codes; the two unused codes behave as ascii
  localparam logic [2:0] LOC_ASCII   = 3'd0;
  localparam logic [2:0] LOC_GB2312  = 3'd1;
  localparam logic [2:0] LOC_GBK     = 3'd2;
  localparam logic [2:0] LOC_GB18030 = 3'd3;
  localparam logic [2:0] LOC_BIG5    = 3'd4;
  localparam logic [2:0] LOC_UTF8    = 3'd5;

  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;

  typedef logic [MaxSequence-1:0][7:0] held_t;
  typedef logic [HeldCntW-1:0]         held_cnt_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_LAST,
    KIND_EMPTY
  } item_kind_e;

  typedef struct packed {
    logic [7:0] data;
    item_kind_e kind;
  } q_entry_t;

  typedef enum logic [1:0] {
    SQ_WAIT,
    SQ_FAIL,
    SQ_OK
  } seq_status_e;

  typedef struct packed {
    seq_status_e status;
    logic [2:0]  len;
  } seq_res_t;

  // second character of a two-character escape, zero when the byte has none
  function automatic logic [7:0] escape_letter(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h07:   r = 8'h61;
      8'h08:   r = 8'h62;
      8'h0C:   r = 8'h66;
      8'h0A:   r = 8'h6E;
      8'h0D:   r = 8'h72;
      8'h09:   r = 8'h74;
      8'h0B:   r = 8'h76;
      8'h5C:   r = 8'h5C;
      8'h22:   r = 8'h22;
      8'h27:   r = 8'h27;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // three decimal digit characters, hundreds in entry 0
  function automatic logic [2:0][7:0] dec_digits(input logic [7:0] b);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    logic [2:0][7:0] d;
    if (b >= 8'd200) begin
      h = 2'd2;
      r = b - 8'd200;
    end else if (b >= 8'd100) begin
      h = 2'd1;
      r = b - 8'd100;
    end else begin
      h = 2'd0;
      r = b;
    end
    // r / 10 for r below 100
    p = {8'd0, r} * 16'd205;
    t = p[14:11];
    o = r - ({4'd0, t} * 8'd10);
    d[0] = CHAR_ZERO + {6'd0, h};
    d[1] = CHAR_ZERO + {4'd0, t};
    d[2] = CHAR_ZERO + {4'd0, o[3:0]};
    return d;
  endfunction

endpackage

// ===== hw/rtl/sle_front.sv =====
// sle_front: input handshake and item classification for the escaper.
// Depends on sle_pkg; feeds the request queue (sle_queue).
`timescale 1ns / 1ps

module sle_front
  import sle_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       empty_string_i,
  input  logic       q_full_i,
  output logic       push_o,
  output q_entry_t   entry_o
);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // an empty request ends the string whatever last_byte says
  always_comb begin
    entry_o.data = data_byte_i;
    if (empty_string_i) begin
      entry_o.kind = KIND_EMPTY;
    end else if (last_byte_i) begin
      entry_o.kind = KIND_LAST;
    end else begin
      entry_o.kind = KIND_BYTE;
    end
  end

endmodule

// ===== hw/rtl/sle_queue.sv =====
// sle_queue: short request queue between the front and the back engine.
// Depends on sle_pkg for the entry type and depth.
`timescale 1ns / 1ps

module sle_queue
  import sle_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  output logic     valid_o,
  output q_entry_t entry_o,
  input  logic     pop_i
);

  q_entry_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]     cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/sle_seqchk.sv =====
// sle_seqchk: judges the held bytes as a multibyte sequence of the selected locale.
// Depends on sle_pkg; used by the back engine (sle_back).
`timescale 1ns / 1ps

module sle_seqchk
  import sle_pkg::*;
(
  input  held_t      held_i,
  input  held_cnt_t  cnt_i,
  input  logic       end_i,
  input  logic [2:0] mode_i,
  output seq_res_t   res_o
);

  function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  seq_status_e miss;
  logic [2:0]  ulen;
  logic        done;
  logic [7:0]  b0, b1, b2, b3;

  assign b0 = held_i[0];
  assign b1 = held_i[1];
  assign b2 = held_i[2];
  assign b3 = held_i[3];

  // utf-8 length from the lead byte, zero for a byte that cannot lead
  always_comb begin
    if (b0 < 8'hC0)      ulen = 3'd0;
    else if (b0 < 8'hE0) ulen = 3'd2;
    else if (b0 < 8'hF0) ulen = 3'd3;
    else if (b0 < 8'hF8) ulen = 3'd4;
    else if (b0 < 8'hFC) ulen = 3'd5;
    else if (b0 < 8'hFE) ulen = 3'd6;
    else                 ulen = 3'd0;
  end

  always_comb begin
    // a missing byte at the end of the string counts as failure
    miss         = end_i ? SQ_FAIL : SQ_WAIT;
    res_o.status = SQ_FAIL;
    res_o.len    = 3'd0;
    done         = 1'b0;
    unique case (mode_i) inside
      LOC_GB2312: begin
        if (in_rng(b0, 8'hA1, 8'hF7)) begin
          if (cnt_i < held_cnt_t'(2)) begin
            res_o.status = miss;
          end else if (in_rng(b1, 8'hA1, 8'hFE)) begin
            res_o.status = SQ_OK;
            res_o.len    = 3'd2;
          end
        end
      end
      LOC_GBK, LOC_GB18030: begin
        if (in_rng(b0, 8'h81, 8'hFE)) begin
          if (cnt_i < held_cnt_t'(2)) begin
            res_o.status = miss;
          end else if (in_rng(b1, 8'h40, 8'hFE) && (b1 != 8'h7F)) begin
            res_o.status = SQ_OK;
            res_o.len    = 3'd2;
          end else if ((mode_i == LOC_GB18030) && in_rng(b1, 8'h30, 8'h39)) begin
            if (cnt_i < held_cnt_t'(3)) begin
              res_o.status = miss;
            end else if (in_rng(b2, 8'h81, 8'hFE)) begin
              if (cnt_i < held_cnt_t'(4)) begin
                res_o.status = miss;
              end else if (in_rng(b3, 8'h30, 8'h39)) begin
                res_o.status = SQ_OK;
                res_o.len    = 3'd4;
              end
            end
          end
        end
      end
      LOC_BIG5: begin
        if (in_rng(b0, 8'h81, 8'hFE)) begin
          if (cnt_i < held_cnt_t'(2)) begin
            res_o.status = miss;
          end else if (in_rng(b1, 8'h40, 8'h7E) || in_rng(b1, 8'hA1, 8'hFE)) begin
            res_o.status = SQ_OK;
            res_o.len    = 3'd2;
          end
        end
      end
      LOC_UTF8: begin
        if ((ulen != 3'd0) && (int'(ulen) <= MaxSequence)) begin
          for (int k = 1; k < MaxSequence; k++) begin
            if (!done && (k < int'(ulen))) begin
              if (k >= int'(cnt_i)) begin
                res_o.status = miss;
                done         = 1'b1;
              end else if (held_i[k][7:6] != 2'b10) begin
                res_o.status = SQ_FAIL;
                done         = 1'b1;
              end
            end
          end
          if (!done) begin
            res_o.status = SQ_OK;
            res_o.len    = ulen;
          end
        end
      end
      default: begin
        res_o.status = SQ_FAIL;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sle_back.sv =====
// sle_back: back engine that holds pending bytes and emits the quoted literal.
// Depends on sle_pkg and sle_seqchk; takes requests from sle_queue.
`timescale 1ns / 1ps

module sle_back
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  q_entry_t   q_entry_i,
  output logic       q_pop_o,
  input  logic [2:0] locale_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  typedef enum logic [2:0] {
    S_FETCH,
    S_OPEN,
    S_DRAIN,
    S_TAIL,
    S_PASS,
    S_CLOSE
  } state_e;

  state_e          state_q, state_d;
  logic            inside_q, inside_d;
  logic            end_q, end_d;
  held_t           held_q, held_d;
  held_cnt_t       cnt_q, cnt_d;
  logic [2:0][7:0] tail_q, tail_d;
  logic [1:0]      tail_n_q, tail_n_d;
  logic [2:0]      pass_n_q, pass_n_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_char_q, out_char_d;
  logic            out_last_q, out_last_d;

  logic            can_emit, emit, pop;
  logic [7:0]      head, esc;
  logic            printable;
  seq_res_t        seq;

  sle_seqchk u_seqchk (
    .held_i (held_q),
    .cnt_i  (cnt_q),
    .end_i  (end_q),
    .mode_i (locale_i),
    .res_o  (seq)
  );

  assign head      = held_q[0];
  assign esc       = escape_letter(head);
  assign printable = (head >= 8'h20) && (head < 8'h7F);
  assign can_emit  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    inside_d   = inside_q;
    end_d      = end_q;
    held_d     = held_q;
    cnt_d      = cnt_q;
    tail_d     = tail_q;
    tail_n_d   = tail_n_q;
    pass_n_d   = pass_n_q;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    emit       = 1'b0;
    pop        = 1'b0;
    q_pop_o    = 1'b0;

    unique case (state_q)
      S_FETCH: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          end_d   = (q_entry_i.kind != KIND_BYTE);
          if ((q_entry_i.kind != KIND_EMPTY) && (cnt_q < held_cnt_t'(MaxSequence))) begin
            held_d[cnt_q] = q_entry_i.data;
            cnt_d         = cnt_q + 1'b1;
          end
          state_d = inside_q ? S_DRAIN : S_OPEN;
        end
      end
      S_OPEN: begin
        if (can_emit) begin
          emit       = 1'b1;
          out_char_d = CHAR_QUOTE;
          out_last_d = 1'b0;
          inside_d   = 1'b1;
          state_d    = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cnt_q == '0) begin
          state_d = end_q ? S_CLOSE : S_FETCH;
        end else if (esc != 8'h00) begin
          if (can_emit) begin
            emit       = 1'b1;
            pop        = 1'b1;
            out_char_d = CHAR_BSLASH;
            out_last_d = 1'b0;
            tail_d[0]  = esc;
            tail_n_d   = 2'd1;
            state_d    = S_TAIL;
          end
        end else if (printable) begin
          if (can_emit) begin
            emit       = 1'b1;
            pop        = 1'b1;
            out_char_d = head;
            out_last_d = 1'b0;
          end
        end else begin
          unique case (seq.status)
            SQ_WAIT: begin
              // lead byte stays held until more bytes arrive
              state_d = end_q ? S_CLOSE : S_FETCH;
            end
            SQ_OK: begin
              if (can_emit) begin
                emit       = 1'b1;
                pop        = 1'b1;
                out_char_d = head;
                out_last_d = 1'b0;
                pass_n_d   = seq.len - 3'd1;
                state_d    = S_PASS;
              end
            end
            default: begin
              if (can_emit) begin
                emit       = 1'b1;
                pop        = 1'b1;
                out_char_d = CHAR_BSLASH;
                out_last_d = 1'b0;
                tail_d     = dec_digits(head);
                tail_n_d   = 2'd3;
                state_d    = S_TAIL;
              end
            end
          endcase
        end
      end
      S_TAIL: begin
        if (can_emit) begin
          emit       = 1'b1;
          out_char_d = tail_q[0];
          out_last_d = 1'b0;
          tail_d[0]  = tail_q[1];
          tail_d[1]  = tail_q[2];
          tail_n_d   = tail_n_q - 2'd1;
          if (tail_n_q == 2'd1) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_PASS: begin
        if (can_emit) begin
          emit       = 1'b1;
          pop        = 1'b1;
          out_char_d = head;
          out_last_d = 1'b0;
          pass_n_d   = pass_n_q - 3'd1;
          if (pass_n_q == 3'd1) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_CLOSE: begin
        if (can_emit) begin
          emit       = 1'b1;
          out_char_d = CHAR_QUOTE;
          out_last_d = 1'b1;
          inside_d   = 1'b0;
          cnt_d      = '0;
          state_d    = S_FETCH;
        end
      end
      default: begin
        state_d = S_FETCH;
      end
    endcase

    // drop the head byte and move the rest down
    if (pop) begin
      for (int i = 0; i < MaxSequence - 1; i++) begin
        held_d[i] = held_q[i+1];
      end
      cnt_d = cnt_q - 1'b1;
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FETCH;
      inside_q    <= 1'b0;
      end_q       <= 1'b0;
      cnt_q       <= '0;
      tail_n_q    <= '0;
      pass_n_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inside_q    <= inside_d;
      end_q       <= end_d;
      cnt_q       <= cnt_d;
      tail_n_q    <= tail_n_d;
      pass_n_q    <= pass_n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    tail_q     <= tail_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

// ===== hw/rtl/string_literal_escaper.sv =====
// String literal escaper: takes a string one byte per request and emits it as a double-quoted
// literal, one character at a time on the output channel. A request is taken into a two-entry
// queue, so the input side keeps accepting while the back engine is busy or the output stalls,
// until the queue is full. The back engine fetches a request and then emits each character
// (opening quote, pass-through byte, each character of a two- or four-character escape,
// closing quote) whenever the output can take it. It then passes once more through the drain
// state, which finds either nothing left to emit or a held lead byte that has to wait for more
// bytes. Possible lead bytes of a multibyte sequence are held (up to six) until the sequence is
// confirmed or fails. The locale register resets to utf8 and should only be written while no
// string request is in flight.
// Depends on sle_pkg, sle_front, sle_queue and sle_back.
`timescale 1ns / 1ps

module string_literal_escaper
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       empty_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i
);

  logic [2:0] locale_q;
  logic       push, q_full, q_valid, q_pop;
  q_entry_t   push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locale_q <= LOC_UTF8;
    end else if (cfg_we_i) begin
      locale_q <= cfg_wdata_i;
    end
  end

  sle_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .empty_string_i (empty_string_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  sle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (q_pop)
  );

  sle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .locale_i    (locale_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// ===== hw/rtl/sle_checker.sv =====
// sle_checker: port-level assertions for the string literal escaper, bound to the top level.
// Depends on sle_pkg for the quote character.
`timescale 1ns / 1ps

module sle_checker
  import sle_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       last_char_o
);

  // tracks whether an opening quote has gone out for the current literal
  logic open_q, open_d;

  always_comb begin
    open_d = open_q;
    if (out_valid_o && out_ready_i) begin
      open_d = !last_char_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_char_o) && $stable(last_char_o))
    else $error("output request changed while stalled");

  a_last_is_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_char_o |-> out_char_o == CHAR_QUOTE)
    else $error("closing mark on a character other than a quote");

  a_open_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !open_q |-> out_char_o == CHAR_QUOTE && !last_char_o)
    else $error("literal does not start with an opening quote");

endmodule

bind string_literal_escaper sle_checker u_sle_checker (.*);
